// File: src/clc_pkg.sv
// Shared types and constants for the character LCD front end.
`timescale 1ns / 1ps
`default_nettype none
package clc_pkg;

  localparam int unsigned ROW_W      = 3;   // row index within a glyph
  localparam int unsigned PIX_W      = 5;   // pixels per glyph row
  localparam int unsigned COL_W      = 7;
  localparam int unsigned LINE_W     = 3;
  localparam int unsigned ROWS_PER_GLYPH = 8;

  localparam logic [COL_W-1:0] COL_MAX   = 7'd127;
  localparam logic [ROW_W-1:0] ROW_LAST  = 3'd7;

  // Display address ranges, one per text line
  localparam logic [7:0] LINE0_LO = 8'h80;
  localparam logic [7:0] LINE0_HI = 8'h93;
  localparam logic [7:0] LINE1_LO = 8'hC0;
  localparam logic [7:0] LINE1_HI = 8'hD3;
  localparam logic [7:0] LINE2_LO = 8'h94;
  localparam logic [7:0] LINE2_HI = 8'hA7;
  localparam logic [7:0] LINE3_LO = 8'hD4;
  localparam logic [7:0] LINE3_HI = 8'hE7;

  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;
  localparam logic [7:0] GLYPH_CODES = 8'h08;

  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_CLEAR      = 3'd1,
    OP_HOME       = 3'd2,
    OP_GLYPH_ADDR = 3'd3,
    OP_DISP_ADDR  = 3'd4,
    OP_DATA       = 3'd5
  } op_e;

  // One decoded byte from the nibble link
  typedef struct packed {
    op_e               kind;
    logic [7:0]        value;
    logic              addr_hit;   // display address fell in a line range
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
  } op_t;

  typedef enum logic [1:0] {
    EV_CLEAR     = 2'd0,
    EV_GLYPH_ROW = 2'd1,
    EV_CHAR      = 2'd2
  } evt_kind_e;

  typedef struct packed {
    evt_kind_e         event_kind;
    logic [7:0]        char_code;
    logic [COL_W-1:0]  cell_column;
    logic [LINE_W-1:0] cell_line;
    logic [ROW_W-1:0]  pattern_row;
    logic [PIX_W-1:0]  row_bits;
    logic              last;
  } evt_t;

endpackage
`default_nettype wire

// File: src/clc_if.sv
// Link and event channel interfaces of the character LCD front end.
`timescale 1ns / 1ps
`default_nettype none
interface clc_link_if;
  logic       valid;
  logic       ready;
  logic [7:0] link_byte;

  modport source (output valid, output link_byte, input ready);
  modport sink   (input valid, input link_byte, output ready);
endinterface

interface clc_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] char_code;
  logic [6:0] cell_column;
  logic [2:0] cell_line;
  logic [2:0] pattern_row;
  logic [4:0] row_bits;
  logic       last;

  modport source (output valid, output event_kind, output char_code, output cell_column,
                  output cell_line, output pattern_row, output row_bits, output last,
                  input ready);
  modport sink   (input valid, input event_kind, input char_code, input cell_column,
                  input cell_line, input pattern_row, input row_bits, input last,
                  output ready);
endinterface
`default_nettype wire

// File: src/clc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module clc_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: src/clc_decode.sv
// Nibble assembler and command decoder for the link byte stream.
`timescale 1ns / 1ps
`default_nettype none
module clc_decode (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    link_byte_i,
  output      clc_pkg::op_t  op_o
);
  import clc_pkg::*;

  logic       phase_q, phase_d;
  logic [3:0] hi_q, hi_d;
  logic       cmd_q, cmd_d;
  logic       cmd_mark;
  logic [7:0] byte_w;

  assign cmd_mark = cmd_q | link_byte_i[7];
  assign byte_w   = {hi_q, link_byte_i[3:0]};

  always_comb begin
    phase_d = phase_q;
    hi_d    = hi_q;
    cmd_d   = cmd_q;
    if (accept_i) begin
      if (!phase_q) begin
        hi_d    = link_byte_i[3:0];
        phase_d = 1'b1;
        cmd_d   = cmd_mark;
      end else begin
        phase_d = 1'b0;
        cmd_d   = 1'b0;
      end
    end
  end

  always_comb begin
    op_o          = '0;
    op_o.kind     = OP_NONE;
    op_o.value    = byte_w;
    if (phase_q) begin
      if (!cmd_mark) begin
        op_o.kind = OP_DATA;
      end else if (byte_w[7]) begin
        op_o.kind = OP_DISP_ADDR;
        op_o.addr_hit = 1'b1;
        if (byte_w >= LINE0_LO && byte_w <= LINE0_HI) begin
          op_o.line = 3'd0;
          op_o.col  = 7'(byte_w - LINE0_LO);
        end else if (byte_w >= LINE1_LO && byte_w <= LINE1_HI) begin
          op_o.line = 3'd1;
          op_o.col  = 7'(byte_w - LINE1_LO);
        end else if (byte_w >= LINE2_LO && byte_w <= LINE2_HI) begin
          op_o.line = 3'd2;
          op_o.col  = 7'(byte_w - LINE2_LO);
        end else if (byte_w >= LINE3_LO && byte_w <= LINE3_HI) begin
          op_o.line = 3'd3;
          op_o.col  = 7'(byte_w - LINE3_LO);
        end else begin
          op_o.addr_hit = 1'b0;
        end
      end else if (byte_w[6]) begin
        op_o.kind = OP_GLYPH_ADDR;
      end else if (|byte_w[5:2]) begin
        op_o.kind = OP_NONE;   // mode commands are ignored
      end else if (byte_w[1]) begin
        op_o.kind = OP_HOME;
      end else if (byte_w[0]) begin
        op_o.kind = OP_CLEAR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      hi_q    <= '0;
      cmd_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hi_q    <= hi_d;
      cmd_q   <= cmd_d;
    end
  end

endmodule
`default_nettype wire

// File: src/char_lcd_controller_front_end.sv
// Top level of the character LCD front end: cursor state, glyph store and event output.
//
// Usage:
//   link_i carries one nibble per request in link_byte[3:0], high nibble first;
//   link_byte[7] on either nibble marks the assembled byte as a command.
//   evt_o carries draw events: clear screen, custom glyph rows, font characters;
//   last is set on the final event caused by one request.
//   A request is taken when the event register is free or being
//   drained. A font character or clear event appears in the cycle after its request.
//   A custom glyph draw reads the glyph RAM one row per cycle while evt_o does
//   not stall and shows eight events, the first after the glyph RAM read and
//   event registers; link_i is held off while the rows go out.
//   When evt_o stalls, the pending event is held and link_i is held off until
//   it is taken, whatever the next request is; a glyph draw waits on its row.
//   Reset clears the cursor, the nibble phase and the glyph contents at once
//   (per-row valid bits), so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module char_lcd_controller_front_end #(
  parameter int unsigned GLYPH_COUNT = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  clc_link_if.sink    link_i,
  clc_evt_if.source   evt_o
);
  import clc_pkg::*;

  localparam int unsigned DEPTH = GLYPH_COUNT * ROWS_PER_GLYPH;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DRAW = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic              tgt_q, tgt_d;        // 1: data goes to the glyph store
  logic [ROW_W-1:0]  rcnt_q, rcnt_d;
  logic              out_vld_q, out_vld_d;
  evt_t              out_q, out_d;
  logic [COL_W-1:0]  dcol_q, dcol_d;
  logic [LINE_W-1:0] dline_q, dline_d;
  logic [2:0]        dcode_q, dcode_d;
  logic [DEPTH-1:0]  vld_q, vld_d;
  logic              rvld_q;

  logic              slot_free, acc;
  op_t               op;
  logic [LINE_W-1:0] gmod [8];
  logic [2:0]        g_cur, g_next;
  logic [ROW_W-1:0]  row_cur;
  logic [COL_W-1:0]  col_adv;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [PIX_W-1:0]  wdata, rdata, rbits;

  // line modulo glyph count, for every possible line value
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      gmod[i] = 3'(i % GLYPH_COUNT);
    end
  end

  assign slot_free    = !out_vld_q || evt_o.ready;
  assign link_i.ready = (state_q == S_IDLE) && slot_free;
  assign acc          = link_i.valid && link_i.ready;

  clc_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (acc),
    .link_byte_i (link_i.link_byte),
    .op_o        (op)
  );

  assign g_cur   = gmod[line_q];
  assign row_cur = col_q[ROW_W-1:0];
  assign g_next  = (4'(g_cur) + 4'd1 == 4'(GLYPH_COUNT)) ? 3'd0 : 3'(g_cur + 3'd1);
  assign col_adv = (col_q < COL_MAX) ? 7'(col_q + 7'd1) : col_q;
  assign waddr   = AW'({g_cur, row_cur});
  assign wdata   = op.value[PIX_W-1:0];
  assign rbits   = rvld_q ? rdata : '0;

  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    line_d    = line_q;
    tgt_d     = tgt_q;
    rcnt_d    = rcnt_q;
    out_vld_d = out_vld_q && !evt_o.ready;
    out_d     = out_q;
    dcol_d    = dcol_q;
    dline_d   = dline_q;
    dcode_d   = dcode_q;
    vld_d     = vld_q;
    we        = 1'b0;
    re        = 1'b0;
    raddr     = AW'({dcode_q, 3'(rcnt_q + 3'd1)});

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (op.kind)
            OP_CLEAR: begin
              col_d     = '0;
              line_d    = '0;
              out_d     = '0;
              out_d.event_kind = EV_CLEAR;
              out_d.last       = 1'b1;
              out_vld_d = 1'b1;
            end
            OP_HOME: begin
              col_d  = '0;
              line_d = '0;
            end
            OP_GLYPH_ADDR: begin
              line_d = gmod[op.value[5:3]];
              col_d  = '0;
              tgt_d  = 1'b1;
            end
            OP_DISP_ADDR: begin
              if (op.addr_hit) begin
                line_d = op.line;
                col_d  = op.col;
              end
              tgt_d = 1'b0;
            end
            OP_DATA: begin
              if (tgt_q) begin
                we           = 1'b1;
                vld_d[waddr] = 1'b1;
                if (row_cur == ROW_LAST) begin
                  col_d  = '0;
                  line_d = g_next;
                end else begin
                  col_d = 7'(row_cur + 3'd1);
                end
              end else if (op.value < GLYPH_CODES) begin
                if (op.value < 8'(GLYPH_COUNT)) begin
                  re      = 1'b1;
                  raddr   = AW'({op.value[2:0], 3'd0});
                  dcode_d = op.value[2:0];
                  dcol_d  = col_q;
                  dline_d = line_q;
                  rcnt_d  = '0;
                  col_d   = col_adv;
                  state_d = S_DRAW;
                end
              end else if (op.value >= PRINT_LO && op.value <= PRINT_HI) begin
                out_d             = '0;
                out_d.event_kind  = EV_CHAR;
                out_d.char_code   = op.value;
                out_d.cell_column = col_q;
                out_d.cell_line   = line_q;
                out_d.last        = 1'b1;
                out_vld_d         = 1'b1;
                col_d             = col_adv;
              end
            end
            default: ;
          endcase
        end
      end
      S_DRAW: begin
        // read data for row rcnt_q is present; next row is fetched as it leaves
        if (slot_free) begin
          out_d.event_kind  = EV_GLYPH_ROW;
          out_d.char_code   = 8'(dcode_q);
          out_d.cell_column = dcol_q;
          out_d.cell_line   = dline_q;
          out_d.pattern_row = rcnt_q;
          out_d.row_bits    = rbits;
          out_d.last        = (rcnt_q == ROW_LAST);
          out_vld_d         = 1'b1;
          if (rcnt_q == ROW_LAST) begin
            state_d = S_IDLE;
          end else begin
            re     = 1'b1;
            rcnt_d = 3'(rcnt_q + 3'd1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  clc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      col_q     <= '0;
      line_q    <= '0;
      tgt_q     <= 1'b0;
      rcnt_q    <= '0;
      out_vld_q <= 1'b0;
      vld_q     <= '0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      line_q    <= line_d;
      tgt_q     <= tgt_d;
      rcnt_q    <= rcnt_d;
      out_vld_q <= out_vld_d;
      vld_q     <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    dcol_q  <= dcol_d;
    dline_q <= dline_d;
    dcode_q <= dcode_d;
    if (re) begin
      rvld_q <= vld_q[raddr];
    end
  end

  assign evt_o.valid       = out_vld_q;
  assign evt_o.event_kind  = out_q.event_kind;
  assign evt_o.char_code   = out_q.char_code;
  assign evt_o.cell_column = out_q.cell_column;
  assign evt_o.cell_line   = out_q.cell_line;
  assign evt_o.pattern_row = out_q.pattern_row;
  assign evt_o.row_bits    = out_q.row_bits;
  assign evt_o.last        = out_q.last;

endmodule
`default_nettype wire

// File: sim/clc_evt_scoreboard.sv
// Scoreboard for the character LCD front end: predicts draw events and compares them.
`timescale 1ns / 1ps
module clc_evt_scoreboard #(
  parameter int unsigned GLYPH_COUNT = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  clc_link_if  link_i,
  clc_evt_if   evt_i,
  output int   fail_count_o,
  output int   pending_o
);
  import clc_pkg::*;

  localparam int unsigned STORE_ROWS = GLYPH_COUNT * ROWS_PER_GLYPH;
  localparam int unsigned SHOW_LIMIT = 10;

  // Shadow copy of the front end state
  logic                low_phase;
  logic [3:0]          hi_nib;
  logic                cmd_held;
  logic [COL_W-1:0]    cur_col;
  logic [LINE_W-1:0]   cur_line;
  logic                to_glyphs;
  logic [PIX_W-1:0]    glyph_rows [STORE_ROWS];

  evt_t expected_events [$];

  function automatic evt_t make_event(evt_kind_e kind, logic [7:0] code,
                                      logic [COL_W-1:0] col, logic [LINE_W-1:0] line,
                                      logic [ROW_W-1:0] row, logic [PIX_W-1:0] bits,
                                      logic is_last);
    evt_t ev;
    ev.event_kind  = kind;
    ev.char_code   = code;
    ev.cell_column = col;
    ev.cell_line   = line;
    ev.pattern_row = row;
    ev.row_bits    = bits;
    ev.last        = is_last;
    return ev;
  endfunction

  task automatic clear_shadow();
    low_phase = 1'b0;
    hi_nib    = 4'd0;
    cmd_held  = 1'b0;
    cur_col   = '0;
    cur_line  = '0;
    to_glyphs = 1'b0;
    for (int i = 0; i < STORE_ROWS; i++) glyph_rows[i] = '0;
  endtask

  task automatic bump_column();
    if (cur_col != COL_MAX) cur_col = cur_col + 7'd1;
  endtask

  task automatic run_command(input logic [7:0] cmd);
    if (cmd[7]) begin
      // display address; outside the four line ranges the cursor stays put
      if (cmd >= LINE0_LO && cmd <= LINE0_HI) begin
        cur_line = 3'd0;
        cur_col  = 7'(cmd - LINE0_LO);
      end else if (cmd >= LINE1_LO && cmd <= LINE1_HI) begin
        cur_line = 3'd1;
        cur_col  = 7'(cmd - LINE1_LO);
      end else if (cmd >= LINE2_LO && cmd <= LINE2_HI) begin
        cur_line = 3'd2;
        cur_col  = 7'(cmd - LINE2_LO);
      end else if (cmd >= LINE3_LO && cmd <= LINE3_HI) begin
        cur_line = 3'd3;
        cur_col  = 7'(cmd - LINE3_LO);
      end
      to_glyphs = 1'b0;
    end else if (cmd[6]) begin
      cur_line  = 3'(int'(cmd[5:3]) % GLYPH_COUNT);
      cur_col   = '0;
      to_glyphs = 1'b1;
    end else if (cmd[5:2] == 4'd0) begin
      // bits 5..2 are mode commands with no effect
      if (cmd[1]) begin
        cur_col  = '0;
        cur_line = '0;
      end else if (cmd[0]) begin
        cur_col  = '0;
        cur_line = '0;
        expected_events.push_back(make_event(EV_CLEAR, 8'd0, '0, '0, '0, '0, 1'b1));
      end
    end
  endtask

  task automatic run_data(input logic [7:0] data);
    int               g;
    logic [ROW_W-1:0] row;
    if (to_glyphs) begin
      g   = int'(cur_line) % GLYPH_COUNT;
      row = cur_col[2:0];
      glyph_rows[g * ROWS_PER_GLYPH + int'(row)] = data[4:0];
      if (row == ROW_LAST) begin
        cur_col  = '0;
        cur_line = 3'((g + 1) % GLYPH_COUNT);
      end else begin
        cur_col = 7'(row) + 7'd1;
      end
    end else if (data < GLYPH_CODES) begin
      if (int'(data) < GLYPH_COUNT) begin
        for (int r = 0; r < ROWS_PER_GLYPH; r++)
          expected_events.push_back(make_event(EV_GLYPH_ROW, data, cur_col, cur_line,
              3'(r), glyph_rows[int'(data) * ROWS_PER_GLYPH + r],
              r == ROWS_PER_GLYPH - 1));
        bump_column();
      end
    end else if (data >= PRINT_LO && data <= PRINT_HI) begin
      expected_events.push_back(make_event(EV_CHAR, data, cur_col, cur_line, '0, '0, 1'b1));
      bump_column();
    end
  endtask

  task automatic take_nibble(input logic [7:0] nib);
    logic [7:0] assembled;
    if (nib[7]) cmd_held = 1'b1;
    if (!low_phase) begin
      hi_nib    = nib[3:0];
      low_phase = 1'b1;
    end else begin
      low_phase = 1'b0;
      assembled = {hi_nib, nib[3:0]};
      if (cmd_held) begin
        cmd_held = 1'b0;
        run_command(assembled);
      end else begin
        run_data(assembled);
      end
    end
  endtask

  task automatic check_event();
    evt_t got;
    evt_t want;
    got.event_kind  = evt_kind_e'(evt_i.event_kind);
    got.char_code   = evt_i.char_code;
    got.cell_column = evt_i.cell_column;
    got.cell_line   = evt_i.cell_line;
    got.pattern_row = evt_i.pattern_row;
    got.row_bits    = evt_i.row_bits;
    got.last        = evt_i.last;
    if (expected_events.size() == 0) begin
      if (fail_count_o < SHOW_LIMIT)
        $display("%0t: unexpected event kind %0d code %h col %0d line %0d row %0d bits %h last %0b",
                 $realtime, got.event_kind, got.char_code, got.cell_column, got.cell_line,
                 got.pattern_row, got.row_bits, got.last);
      fail_count_o = fail_count_o + 1;
    end else begin
      want = expected_events.pop_front();
      if (got !== want) begin
        if (fail_count_o < SHOW_LIMIT) begin
          $display("%0t: event mismatch", $realtime);
          $display("  expected kind %0d code %h col %0d line %0d row %0d bits %h last %0b",
                   want.event_kind, want.char_code, want.cell_column, want.cell_line,
                   want.pattern_row, want.row_bits, want.last);
          $display("  actual   kind %0d code %h col %0d line %0d row %0d bits %h last %0b",
                   got.event_kind, got.char_code, got.cell_column, got.cell_line,
                   got.pattern_row, got.row_bits, got.last);
        end
        fail_count_o = fail_count_o + 1;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_shadow();
      expected_events.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // request first: an event never shows in the cycle of its own request
      if (link_i.valid && link_i.ready) take_nibble(link_i.link_byte);
      if (evt_i.valid && evt_i.ready) check_event();
      pending_o = expected_events.size();
    end
  end

endmodule

// File: sim/testbench.sv
// Top of the front end testbench: clock, reset, link stimulus, event sink and verdict.
`timescale 1ns / 1ps
module testbench;
  import clc_pkg::*;

  localparam int unsigned GLYPH_COUNT = 8;

  logic clk_i = 1'b0;
  logic rst_ni;

  clc_link_if link_bus ();
  clc_evt_if  evt_bus ();

  int fail_count;
  int pending;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_active    = 1'b0;

  char_lcd_controller_front_end #(.GLYPH_COUNT(GLYPH_COUNT)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .link_i (link_bus),
    .evt_o  (evt_bus)
  );

  clc_evt_scoreboard #(.GLYPH_COUNT(GLYPH_COUNT)) u_scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .link_i       (link_bus),
    .evt_i        (evt_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #4 clk_i = ~clk_i;

  // Event sink; a long hold-off overrides the random stalls
  initial begin
    evt_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_active) begin
        evt_bus.ready <= 1'b0;
      end else begin
        evt_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  // Called right after a rising edge; returns at the edge that accepts the request.
  task automatic send_nibble(input logic [7:0] nib);
    logic took;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      link_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    link_bus.valid     <= 1'b1;
    link_bus.link_byte <= nib;
    do begin
      @(negedge clk_i);
      took = link_bus.ready;
      @(posedge clk_i);
    end while (!took);
  endtask

  // Command mark lands on the first, second or both nibbles; bits 6..4 are noise
  task automatic send_byte(input logic [7:0] value, input bit is_cmd);
    logic [1:0] marks;
    marks = is_cmd ? 2'($urandom_range(3, 1)) : 2'b00;
    send_nibble({marks[1], 3'($urandom), value[7:4]});
    send_nibble({marks[0], 3'($urandom), value[3:0]});
  endtask

  task automatic set_phase(input int idle_pct, input int stall_pct);
    link_bus.valid <= 1'b0;
    @(negedge clk_i);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    @(posedge clk_i);
  endtask

  task automatic send_random_traffic(input int nibbles);
    int          sent;
    int          pick;
    int          rows;
    logic [7:0]  line_base [4];
    line_base[0] = LINE0_LO;
    line_base[1] = LINE1_LO;
    line_base[2] = LINE2_LO;
    line_base[3] = LINE3_LO;
    sent = 0;
    while (sent < nibbles) begin
      pick = $urandom_range(99, 0);
      if (pick < 35) begin
        send_byte(8'($urandom_range(126, 32)), 1'b0);
        sent += 2;
      end else if (pick < 50) begin
        send_byte(8'($urandom_range(7, 0)), 1'b0);
        sent += 2;
      end else if (pick < 62) begin
        // define some glyph rows, often running past row 7
        send_byte({2'b01, 3'($urandom), 3'($urandom)}, 1'b1);
        rows = $urandom_range(10, 1);
        repeat (rows) send_byte(8'($urandom), 1'b0);
        sent += 2 + 2 * rows;
      end else if (pick < 74) begin
        send_byte(line_base[$urandom_range(3, 0)] + 8'($urandom_range(19, 0)), 1'b1);
        sent += 2;
      end else if (pick < 78) begin
        send_byte(8'($urandom_range(255, 128)), 1'b1);
        sent += 2;
      end else if (pick < 83) begin
        send_byte({6'd0, 2'($urandom_range(3, 1))}, 1'b1);
        sent += 2;
      end else if (pick < 89) begin
        send_byte(8'($urandom), 1'b1);
        sent += 2;
      end else if (pick < 95) begin
        send_byte(8'($urandom), 1'b0);
        sent += 2;
      end else begin
        // stray nibble shifts the byte framing
        send_nibble(8'($urandom));
        sent += 1;
      end
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    link_bus.valid     <= 1'b0;
    link_bus.link_byte <= 8'd0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    send_byte(8'h00, 1'b1);   // zero command
    send_byte(8'h01, 1'b1);   // clear
    send_byte(PRINT_LO, 1'b0);
    send_byte(PRINT_HI, 1'b0);
    send_byte(8'h7F, 1'b0);   // not printable
    send_byte(8'hFF, 1'b0);
    send_byte(8'h02, 1'b1);   // home
    send_byte(8'h3C, 1'b1);   // mode bits only
    send_byte(8'h7F, 1'b1);   // glyph address, last glyph
    send_byte(8'hFF, 1'b0);   // row 0 of that glyph
    send_byte(LINE3_HI, 1'b1);
    send_byte(8'h07, 1'b0);   // draw last glyph
    send_byte(8'h00, 1'b0);   // draw first glyph
    send_byte(8'hFF, 1'b1);   // address outside every line range
    send_byte(8'h1F, 1'b0);

    // no idling, with a long receiver hold-off in the middle
    fork
      begin
        repeat (4) @(negedge clk_i);
        hold_active = 1'b1;
        repeat (400) @(negedge clk_i);
        hold_active = 1'b0;
      end
      begin
        send_random_traffic(32);
      end
    join

    set_phase(55, 0);
    send_random_traffic(32);
    set_phase(0, 55);
    send_random_traffic(32);
    set_phase(11, 11);
    send_random_traffic(32);

    link_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: files.f
src/clc_pkg.sv
src/clc_if.sv
src/clc_ram.sv
src/clc_decode.sv
src/char_lcd_controller_front_end.sv
sim/clc_evt_scoreboard.sv
sim/testbench.sv
